// File: rtl/rbls_pkg.sv
// Shared types and constants for the ring border line scanner.
`timescale 1ns / 1ps

package rbls_pkg;

  // Pixel color classes
  localparam logic [2:0] ClsNone  = 3'd0;
  localparam logic [2:0] ClsBlue  = 3'd1;
  localparam logic [2:0] ClsRed   = 3'd2;
  localparam logic [2:0] ClsGreen = 3'd3;
  localparam logic [2:0] ClsBlack = 3'd4;
  localparam logic [2:0] ClsWhite = 3'd5;

  localparam int unsigned CntBits     = 9;
  localparam logic [CntBits-1:0] NoneCountMax = '1;
  localparam logic [7:0] InvalidLimitReset   = 8'd10;

  // Configuration register file
  localparam int unsigned CfgAddrBits = 3;
  localparam logic        RegInvalidLimit = 1'b0;

  typedef enum logic [1:0] {
    RegionInitial = 2'd0,
    RegionBlue    = 2'd1,
    RegionRed     = 2'd2,
    RegionPastRed = 2'd3
  } region_e;

  typedef enum logic [1:0] {
    StFound    = 2'd0,
    StNotFound = 2'd1,
    StRejected = 2'd2
  } status_e;

  typedef struct packed {
    region_e            region;
    logic [2:0]         prev_class;
    logic               prev_valid;
    logic [CntBits-1:0] none_count;
    logic               border_found;
    logic               line_active;
    logic [2:0]         held_dir;
  } line_ctrl_t;

endpackage

// File: rtl/rbls_cfg.sv
// APB-style register file holding the none-pixel limit.
`timescale 1ns / 1ps

module rbls_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rbls_pkg::CfgAddrBits-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [7:0]                      invalid_limit_o
);
  import rbls_pkg::*;

  logic [7:0] limit_q;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[CfgAddrBits-1];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= InvalidLimitReset;
    end else if (wr_en && (reg_sel == RegInvalidLimit)) begin
      limit_q <= pwdata[7:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegInvalidLimit: prdata = {24'd0, limit_q};
      default:         prdata = 32'd0;
    endcase
  end

  assign invalid_limit_o = limit_q;

endmodule

// File: rtl/rbls_step.sv
// Per-pixel line state update: none counter, run detection, region machine.
`timescale 1ns / 1ps

module rbls_step #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic [7:0]             invalid_limit_i,
  input  logic [2:0]             cls_i,
  input  logic [COORD_BITS-1:0]  px_i,
  input  logic [COORD_BITS-1:0]  py_i,
  input  logic                   first_i,
  input  logic                   last_i,
  input  logic [2:0]             dir_i,
  input  rbls_pkg::line_ctrl_t   ctrl_i,
  input  logic [COORD_BITS-1:0]  prev_x_i,
  input  logic [COORD_BITS-1:0]  prev_y_i,
  input  logic [COORD_BITS-1:0]  inner_x_i,
  input  logic [COORD_BITS-1:0]  inner_y_i,
  input  logic [COORD_BITS-1:0]  outer_x_i,
  input  logic [COORD_BITS-1:0]  outer_y_i,
  output rbls_pkg::line_ctrl_t   ctrl_o,
  output logic [COORD_BITS-1:0]  prev_x_o,
  output logic [COORD_BITS-1:0]  prev_y_o,
  output logic [COORD_BITS-1:0]  inner_x_o,
  output logic [COORD_BITS-1:0]  inner_y_o,
  output logic [COORD_BITS-1:0]  outer_x_o,
  output logic [COORD_BITS-1:0]  outer_y_o,
  output logic                   res_valid_o,
  output rbls_pkg::status_e      res_status_o,
  output logic [COORD_BITS-1:0]  res_inner_x_o,
  output logic [COORD_BITS-1:0]  res_inner_y_o,
  output logic [COORD_BITS-1:0]  res_outer_x_o,
  output logic [COORD_BITS-1:0]  res_outer_y_o
);
  import rbls_pkg::*;

  line_ctrl_t         eff;
  logic [CntBits-1:0] cnt;
  logic               ended;
  logic               reject;
  logic               found;

  always_comb begin
    eff       = ctrl_i;
    prev_x_o  = prev_x_i;
    prev_y_o  = prev_y_i;
    inner_x_o = inner_x_i;
    inner_y_o = inner_y_i;
    outer_x_o = outer_x_i;
    outer_y_o = outer_y_i;
    // new line: clear running state, latch direction
    if (first_i) begin
      eff.region       = RegionInitial;
      eff.prev_class   = ClsNone;
      eff.prev_valid   = 1'b0;
      eff.none_count   = '0;
      eff.border_found = 1'b0;
      eff.line_active  = 1'b1;
      eff.held_dir     = dir_i;
      prev_x_o  = '0;
      prev_y_o  = '0;
      inner_x_o = '0;
      inner_y_o = '0;
      outer_x_o = '0;
      outer_y_o = '0;
    end

    ctrl_o       = eff;
    ended        = 1'b0;
    reject       = 1'b0;
    res_valid_o  = 1'b0;
    res_status_o = StNotFound;
    cnt          = eff.none_count;

    if (eff.line_active) begin
      if (cls_i == ClsNone) begin
        if (eff.none_count != NoneCountMax) begin
          cnt = eff.none_count + 1'b1;
        end
        ctrl_o.none_count = cnt;
        ended = (cnt > {1'b0, invalid_limit_i});
      end

      if (!ended) begin
        if (!eff.prev_valid || (cls_i != eff.prev_class)) begin
          // start of a new run
          prev_x_o          = px_i;
          prev_y_o          = py_i;
          ctrl_o.prev_class = cls_i;
          ctrl_o.prev_valid = 1'b1;
        end else begin
          unique case (eff.region)
            RegionInitial: begin
              if (cls_i == ClsBlue) begin
                ctrl_o.region = RegionBlue;
              end else if (cls_i != ClsBlack && cls_i != ClsNone) begin
                reject = 1'b1;
              end
            end
            RegionBlue: begin
              if (cls_i == ClsRed) begin
                inner_x_o     = prev_x_o;
                inner_y_o     = prev_y_o;
                ctrl_o.region = RegionRed;
              end else if (cls_i == ClsGreen) begin
                reject = 1'b1;
              end
            end
            RegionRed: begin
              if (cls_i == ClsBlue) begin
                reject = 1'b1;
              end else if (cls_i == ClsGreen || cls_i == ClsNone ||
                           cls_i == ClsBlack || cls_i == ClsWhite) begin
                outer_x_o           = prev_x_o;
                outer_y_o           = prev_y_o;
                ctrl_o.border_found = 1'b1;
                ctrl_o.region       = RegionPastRed;
              end
            end
            default: ;
          endcase
        end
        if (!reject) begin
          ended = last_i;
        end
      end

      if (reject) begin
        res_valid_o        = 1'b1;
        res_status_o       = StRejected;
        ctrl_o.line_active = 1'b0;
      end else if (ended) begin
        res_valid_o        = 1'b1;
        res_status_o       = ctrl_o.border_found ? StFound : StNotFound;
        ctrl_o.line_active = 1'b0;
      end
    end
  end

  // border points are reported only for a found border
  assign found         = (res_status_o == StFound);
  assign res_inner_x_o = found ? inner_x_o : '0;
  assign res_inner_y_o = found ? inner_y_o : '0;
  assign res_outer_x_o = found ? outer_x_o : '0;
  assign res_outer_y_o = found ? outer_y_o : '0;

endmodule

// File: rtl/ring_border_line_scanner.sv
// Top level of the ring border line scanner.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one classified pixel per
//   item, walked from the marker center outward, with first_of_line opening
//   a line and last_of_line closing it. Pixels outside an open line are
//   dropped without a result.
//   Output channel (out_valid_o / out_stall_i) carries one item per finished
//   line: status, red inner and outer border points, and line direction.
//   A line also ends early on a rejected color order or once the none-pixel
//   count exceeds the invalid_limit register (APB offset 0, reset 10).
// Timing:
//   An accepted pixel is held in the input register; once it moves on, the line
//   state is updated and any result is written to the output register that
//   drives out_valid_o. One pixel per cycle is sustained while the output is
//   not stalled; the only loop is the state update in the step logic.
// Stall:
//   While out_stall_i holds back a waiting result, the input register holds
//   its pixel and in_stall_o rises only then.
// Reset:
//   Clears both valid flags and the line state; no line is open afterwards.
//   The limit register returns to 10.

module ring_border_line_scanner #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // pixel input
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [2:0]                       color_class_i,
  input  logic [COORD_BITS-1:0]            pixel_x_i,
  input  logic [COORD_BITS-1:0]            pixel_y_i,
  input  logic                             first_of_line_i,
  input  logic                             last_of_line_i,
  input  logic [2:0]                       direction_i,
  // line result
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       line_status_o,
  output logic [COORD_BITS-1:0]            inner_x_o,
  output logic [COORD_BITS-1:0]            inner_y_o,
  output logic [COORD_BITS-1:0]            outer_x_o,
  output logic [COORD_BITS-1:0]            outer_y_o,
  output logic [2:0]                       line_direction_o,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rbls_pkg::CfgAddrBits-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import rbls_pkg::*;

  logic [7:0] invalid_limit;

  // input register
  logic                  s1_valid_q, s1_valid_d;
  logic [2:0]            s1_cls_q;
  logic [COORD_BITS-1:0] s1_x_q, s1_y_q;
  logic                  s1_first_q, s1_last_q;
  logic [2:0]            s1_dir_q;

  // line state
  line_ctrl_t            ctrl_q, ctrl_d;
  logic [COORD_BITS-1:0] prev_x_q, prev_y_q, prev_x_d, prev_y_d;
  logic [COORD_BITS-1:0] in_x_q, in_y_q, in_x_d, in_y_d;
  logic [COORD_BITS-1:0] out_x_q, out_y_q, out_x_d, out_y_d;

  // result register
  logic                  out_valid_q, out_valid_d;
  status_e               res_status_q;
  logic [COORD_BITS-1:0] res_ix_q, res_iy_q, res_ox_q, res_oy_q;
  logic [2:0]            res_dir_q;

  logic                  res_valid;
  status_e               res_status;
  logic [COORD_BITS-1:0] res_ix, res_iy, res_ox, res_oy;

  logic move;     // input register item is processed this cycle
  logic out_free; // output register can take a new result
  logic in_acc;

  rbls_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .invalid_limit_o (invalid_limit)
  );

  rbls_step #(.COORD_BITS(COORD_BITS)) u_step (
    .invalid_limit_i (invalid_limit),
    .cls_i           (s1_cls_q),
    .px_i            (s1_x_q),
    .py_i            (s1_y_q),
    .first_i         (s1_first_q),
    .last_i          (s1_last_q),
    .dir_i           (s1_dir_q),
    .ctrl_i          (ctrl_q),
    .prev_x_i        (prev_x_q),
    .prev_y_i        (prev_y_q),
    .inner_x_i       (in_x_q),
    .inner_y_i       (in_y_q),
    .outer_x_i       (out_x_q),
    .outer_y_i       (out_y_q),
    .ctrl_o          (ctrl_d),
    .prev_x_o        (prev_x_d),
    .prev_y_o        (prev_y_d),
    .inner_x_o       (in_x_d),
    .inner_y_o       (in_y_d),
    .outer_x_o       (out_x_d),
    .outer_y_o       (out_y_d),
    .res_valid_o     (res_valid),
    .res_status_o    (res_status),
    .res_inner_x_o   (res_ix),
    .res_inner_y_o   (res_iy),
    .res_outer_x_o   (res_ox),
    .res_outer_y_o   (res_oy)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign move       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_free ? (move && res_valid) : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ctrl_q      <= '{region: RegionInitial, default: '0};
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (move) begin
        ctrl_q <= ctrl_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cls_q   <= color_class_i;
      s1_x_q     <= pixel_x_i;
      s1_y_q     <= pixel_y_i;
      s1_first_q <= first_of_line_i;
      s1_last_q  <= last_of_line_i;
      s1_dir_q   <= direction_i;
    end
    if (move) begin
      prev_x_q <= prev_x_d;
      prev_y_q <= prev_y_d;
      in_x_q   <= in_x_d;
      in_y_q   <= in_y_d;
      out_x_q  <= out_x_d;
      out_y_q  <= out_y_d;
    end
    if (move && res_valid) begin
      res_status_q <= res_status;
      res_ix_q     <= res_ix;
      res_iy_q     <= res_iy;
      res_ox_q     <= res_ox;
      res_oy_q     <= res_oy;
      res_dir_q    <= ctrl_d.held_dir;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign line_status_o    = res_status_q;
  assign inner_x_o        = res_ix_q;
  assign inner_y_o        = res_iy_q;
  assign outer_x_o        = res_ox_q;
  assign outer_y_o        = res_oy_q;
  assign line_direction_o = res_dir_q;

endmodule

// File: rtl/rbls_checker.sv
// Port-level assertions for the ring border line scanner, with bind.
`timescale 1ns / 1ps

module rbls_assertions #(
  parameter int unsigned COORD_BITS = 12
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic [2:0]                       color_class_i,
  input logic [COORD_BITS-1:0]            pixel_x_i,
  input logic [COORD_BITS-1:0]            pixel_y_i,
  input logic                             first_of_line_i,
  input logic                             last_of_line_i,
  input logic [2:0]                       direction_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [1:0]                       line_status_o,
  input logic [COORD_BITS-1:0]            inner_x_o,
  input logic [COORD_BITS-1:0]            inner_y_o,
  input logic [COORD_BITS-1:0]            outer_x_o,
  input logic [COORD_BITS-1:0]            outer_y_o,
  input logic [2:0]                       line_direction_o,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [rbls_pkg::CfgAddrBits-1:0] paddr,
  input logic [31:0]                      pwdata,
  input logic [31:0]                      prdata,
  input logic                             pready
);
  import rbls_pkg::*;

  // a held result keeps its status, x points and direction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_status_o) &&
      $stable(inner_x_o) && $stable(outer_x_o) && $stable(line_direction_o))
    else $error("held result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (line_status_o == StFound || line_status_o == StNotFound ||
                     line_status_o == StRejected))
    else $error("undefined line status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_status_o != StFound |->
      inner_x_o == '0 && inner_y_o == '0 && outer_x_o == '0 && outer_y_o == '0)
    else $error("border points reported without a found border");

  // input backpressure only while a result is held back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free output");

  // a fresh result must stem from a pixel accepted through the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching pixel");

endmodule

bind ring_border_line_scanner rbls_assertions #(.COORD_BITS(COORD_BITS)) u_rbls_checker (.*);
